// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge once reset is released
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== sv/pmig_pkg.sv =====
`default_nettype none

package pmig_pkg;

    localparam int VTX_W = 13;
    localparam int CFG_W = 7;
    localparam int MODE_W = 2;
    localparam int SEC_W = 3;

    typedef logic [VTX_W-1:0] t_vtx;

    // mesh kinds
    localparam logic [MODE_W-1:0] MODE_OPEN_CYL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSED_CYL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEMI       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CAPSULE    = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_SLICES = 2'd1;
    localparam logic [1:0] CFG_STACKS = 2'd2;

    // reset values
    localparam logic [MODE_W-1:0] MODE_RST   = MODE_CAPSULE;
    localparam logic [CFG_W-1:0]  SLICES_RST = 7'd16;
    localparam logic [CFG_W-1:0]  STACKS_RST = 7'd10;

    // mesh sections
    localparam logic [SEC_W-1:0] SEC_CYL_SIDE  = 3'd0;
    localparam logic [SEC_W-1:0] SEC_CYL_CAPS  = 3'd1;
    localparam logic [SEC_W-1:0] SEC_TOP_FAN   = 3'd0;
    localparam logic [SEC_W-1:0] SEC_TOP_QUADS = 3'd1;
    localparam logic [SEC_W-1:0] SEC_BOT_FAN   = 3'd2;
    localparam logic [SEC_W-1:0] SEC_BOT_QUADS = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BAND      = 3'd4;

endpackage

`default_nettype wire

// ===== sv/primitive_mesh_index_generator_core.sv =====
// triangle index generator for cylinder, hemisphere and capsule meshes
// result word is registered and appears in the cycle after its request word is accepted
// throughput: one triangle per cycle while the triangle stream is ready; the single result register stalls requests
// position counters step once per accepted request word; ring offset is kept as a running sum
// reset: mode capsule, 16 slices, 10 stacks, position at the first triangle
`default_nettype none

`include "assert_macros.svh"

module primitive_mesh_index_generator_core #(
    parameter int MAX_SLICES = 64,
    parameter int MAX_STACKS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [6:0]  i_cfg_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    // triangle stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [12:0] vertex_a, [25:13] vertex_b,
                                             // [38:26] vertex_c, [39] zero
    output logic             m_axis_tlast    // last_triangle
);

    localparam int SLW = $clog2(MAX_SLICES + 1);
    localparam int STW = $clog2(MAX_STACKS + 1);
    localparam int PW  = (MAX_SLICES > 2) ? $clog2(MAX_SLICES) : 1;
    localparam int RW  = (MAX_STACKS > 2) ? $clog2(MAX_STACKS) : 1;
    localparam int VW  = pmig_pkg::VTX_W;
    localparam int SW  = pmig_pkg::SEC_W;

    logic [pmig_pkg::MODE_W-1:0] r_mode;
    logic [pmig_pkg::CFG_W-1:0]  r_slices;
    logic [pmig_pkg::CFG_W-1:0]  r_stacks;

    logic [SW-1:0] r_section, n_section;
    logic [RW-1:0] r_ring, n_ring;
    logic [VW-1:0] r_ring_off, n_ring_off;
    logic [PW-1:0] r_slice_pos, n_slice_pos;
    logic          r_half, n_half;

    logic          r_out_valid;
    pmig_pkg::t_vtx r_va, r_vb, r_vc, n_va, n_vb, n_vc;
    logic          r_last, n_last;

    logic [SLW-1:0] w_slices;
    logic [STW-1:0] w_stacks;
    logic           w_in_fire;
    logic           w_restart;
    logic           w_cfg_hit;

    logic [SW-1:0]  c_sec;
    logic [RW-1:0]  c_ring;
    logic [VW-1:0]  c_ring_off;
    logic [PW-1:0]  c_slice;
    logic           c_half;

    logic [SLW-1:0] w_i1;
    logic [PW-1:0]  w_n;
    logic           w_halves2;
    logic [STW-1:0] w_rings;
    logic [SW-1:0]  w_num_sec;
    logic [STW+SLW-1:0] w_prod;
    logic [VW-1:0]  w_hv;

    // effective sizes
    always_comb begin
        if (r_slices < 7'd3) begin
            w_slices = SLW'(3);
        end else if (32'(r_slices) > MAX_SLICES) begin
            w_slices = SLW'(MAX_SLICES);
        end else begin
            w_slices = SLW'(r_slices);
        end
        if (r_stacks < 7'd2) begin
            w_stacks = STW'(2);
        end else if (32'(r_stacks) > MAX_STACKS) begin
            w_stacks = STW'(MAX_STACKS);
        end else begin
            w_stacks = STW'(r_stacks);
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_restart     = s_axis_tdata[0];
    assign w_cfg_hit     = i_cfg_we && (i_cfg_idx == pmig_pkg::CFG_MODE
                                     || i_cfg_idx == pmig_pkg::CFG_SLICES
                                     || i_cfg_idx == pmig_pkg::CFG_STACKS);

    // vertices per half of a sphere-like mesh
    assign w_prod = (STW+SLW)'(w_stacks - STW'(1)) * (STW+SLW)'(w_slices);
    assign w_hv   = VW'(w_prod) + VW'(1);

    // position this word works on
    always_comb begin
        c_sec      = w_restart ? '0 : r_section;
        c_ring     = w_restart ? '0 : r_ring;
        c_ring_off = w_restart ? '0 : r_ring_off;
        c_slice    = w_restart ? '0 : r_slice_pos;
        c_half     = w_restart ? 1'b0 : r_half;
    end

    assign w_i1 = SLW'(c_slice) + SLW'(1);
    assign w_n  = (w_i1 == w_slices) ? '0 : PW'(w_i1);

    always_comb begin
        w_halves2 = 1'b1;
        w_rings   = STW'(1);
        unique case (r_mode)
            pmig_pkg::MODE_OPEN_CYL: begin
                w_num_sec = SW'(1);
            end
            pmig_pkg::MODE_CLOSED_CYL: begin
                w_num_sec = SW'(2);
            end
            pmig_pkg::MODE_HEMI: begin
                w_num_sec = SW'(2);
                w_halves2 = (c_sec != pmig_pkg::SEC_TOP_FAN);
                if (c_sec == pmig_pkg::SEC_TOP_QUADS) begin
                    w_rings = w_stacks - STW'(1);
                end
            end
            default: begin
                w_num_sec = SW'(5);
                w_halves2 = (c_sec != pmig_pkg::SEC_TOP_FAN)
                         && (c_sec != pmig_pkg::SEC_BOT_FAN);
                if (c_sec == pmig_pkg::SEC_TOP_QUADS || c_sec == pmig_pkg::SEC_BOT_QUADS) begin
                    w_rings = w_stacks - STW'(2);
                end
            end
        endcase
    end

    // step to the next triangle
    always_comb begin
        logic [SW-1:0] nsec;
        nsec        = c_sec + SW'(1);
        n_section   = c_sec;
        n_ring      = c_ring;
        n_ring_off  = c_ring_off;
        n_slice_pos = c_slice;
        n_half      = 1'b0;
        n_last      = 1'b0;
        if (r_mode == pmig_pkg::MODE_CAPSULE && w_stacks == STW'(2)
                && (nsec == pmig_pkg::SEC_TOP_QUADS || nsec == pmig_pkg::SEC_BOT_QUADS)) begin
            nsec = nsec + SW'(1);
        end
        if (w_halves2 && !c_half) begin
            n_half = 1'b1;
        end else if (w_i1 < w_slices) begin
            n_slice_pos = PW'(w_i1);
        end else begin
            n_slice_pos = '0;
            if (STW'(c_ring) + STW'(1) < w_rings) begin
                n_ring     = c_ring + RW'(1);
                n_ring_off = c_ring_off + VW'(w_slices);
            end else begin
                n_ring     = '0;
                n_ring_off = '0;
                if (nsec >= w_num_sec) begin
                    n_section = '0;
                    n_last    = 1'b1;
                end else begin
                    n_section = nsec;
                end
            end
        end
    end

    // vertex indices
    always_comb begin
        logic [VW-1:0] vi, vn, vs, r0, r1, q0, q1, q2, q3, top, bot;
        vi  = VW'(c_slice);
        vn  = VW'(w_n);
        vs  = VW'(w_slices);
        r0  = ((c_sec == pmig_pkg::SEC_BOT_QUADS) ? w_hv : '0) + c_ring_off + VW'(1);
        r1  = r0 + vs;
        q0  = r0 + vi;
        q1  = r0 + vn;
        q2  = r1 + vn;
        q3  = r1 + vi;
        top = w_hv - vs;
        bot = (w_hv << 1) - vs;
        n_va = '0;
        n_vb = '0;
        n_vc = '0;
        if (r_mode == pmig_pkg::MODE_OPEN_CYL || r_mode == pmig_pkg::MODE_CLOSED_CYL) begin
            if (c_sec == pmig_pkg::SEC_CYL_SIDE) begin
                n_va = vi << 1;
                n_vb = c_half ? ((vn << 1) + VW'(1)) : (vn << 1);
                n_vc = c_half ? ((vi << 1) + VW'(1)) : ((vn << 1) + VW'(1));
            end else if (!c_half) begin
                n_va = (vi << 1) + VW'(1);
                n_vb = (vn << 1) + VW'(1);
                n_vc = vs << 1;
            end else begin
                n_va = (vs << 1) + VW'(1);
                n_vb = vn << 1;
                n_vc = vi << 1;
            end
        end else begin
            case (c_sec)
                pmig_pkg::SEC_TOP_FAN: begin
                    n_va = vi + VW'(1);
                    n_vb = vn + VW'(1);
                    n_vc = '0;
                end
                pmig_pkg::SEC_TOP_QUADS: begin
                    n_va = c_half ? q3 : q2;
                    n_vb = c_half ? q2 : q1;
                    n_vc = q0;
                end
                pmig_pkg::SEC_BOT_FAN: begin
                    n_va = w_hv;
                    n_vb = w_hv + vn + VW'(1);
                    n_vc = w_hv + vi + VW'(1);
                end
                pmig_pkg::SEC_BOT_QUADS: begin
                    n_va = q0;
                    n_vb = c_half ? q2 : q1;
                    n_vc = c_half ? q3 : q2;
                end
                default: begin
                    n_va = top + vi;
                    n_vb = c_half ? (bot + vn) : (bot + vi);
                    n_vc = c_half ? (top + vn) : (bot + vn);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= pmig_pkg::MODE_RST;
            r_slices    <= pmig_pkg::SLICES_RST;
            r_stacks    <= pmig_pkg::STACKS_RST;
            r_section   <= '0;
            r_ring      <= '0;
            r_ring_off  <= '0;
            r_slice_pos <= '0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_hit) begin
                unique case (i_cfg_idx)
                    pmig_pkg::CFG_MODE:   r_mode   <= i_cfg_data[pmig_pkg::MODE_W-1:0];
                    pmig_pkg::CFG_SLICES: r_slices <= i_cfg_data;
                    default:              r_stacks <= i_cfg_data;
                endcase
                r_section   <= '0;
                r_ring      <= '0;
                r_ring_off  <= '0;
                r_slice_pos <= '0;
                r_half      <= 1'b0;
            end else if (w_in_fire) begin
                r_section   <= n_section;
                r_ring      <= n_ring;
                r_ring_off  <= n_ring_off;
                r_slice_pos <= n_slice_pos;
                r_half      <= n_half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_va   <= n_va;
            r_vb   <= n_vb;
            r_vc   <= n_vc;
            r_last <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_vc, r_vb, r_va};
    assign m_axis_tlast  = r_last;

    `ASSERT_CLK(a_slice_in_range, i_clk, i_rst_n,
        SLW'(r_slice_pos) < w_slices, "slice position beyond slice count")
    `ASSERT_CLK(a_half_only_in_quads, i_clk, i_rst_n,
        (r_half && !w_restart) |-> w_halves2, "second half set in a fan section")
    `ASSERT_CLK(a_ring_off_zero, i_clk, i_rst_n,
        (r_ring == '0) |-> (r_ring_off == '0), "ring offset out of step with ring")
    `ASSERT_CLK(a_wrap_clears, i_clk, i_rst_n,
        (w_in_fire && n_last) |=> (r_section == '0 && r_ring == '0 && r_slice_pos == '0),
        "position not cleared after last triangle")
    `ASSERT_ALWAYS(a_ready_when_empty, i_clk,
        !r_out_valid |-> s_axis_tready, "request stalled with empty result register")

endmodule

`default_nettype wire
